[src/assert_macros.svh]
// Concurrent assertion helpers, clocked on the rising edge, off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

[src/bbm_pkg.sv]
package bbm_pkg;

  localparam int MAX_COLS   = 1024;
  localparam int MAX_ROWS   = 1024;
  localparam int MAX_WIN    = 16;
  localparam int STORE_ROWS = MAX_WIN - 1;

  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int SLOT_W  = $clog2(STORE_ROWS);
  localparam int LS_AW   = SLOT_W + COL_W;
  localparam int CFG_W   = 11;
  localparam int WIN_W   = 5;
  localparam int PIX_W   = 8;
  localparam int NCH     = 3;
  localparam int CSUM_W  = 12;
  localparam int WSUM_W  = 16;
  localparam int AREA_W  = 9;
  localparam int REM_W   = AREA_W + 1;
  localparam int DCNT_W  = 5;
  localparam int CFG_IDX_W = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_ROWS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_COLS   = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COL,
    S_WRITE,
    S_WIN,
    S_DIV,
    S_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic start;
    logic col_step;
    logic wr_en;
    logic win_step;
    logic div_start;
    logic load;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic col_done;
    logic emit;
    logic win_done;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

[src/box_blur_window_mean_unit.sv]
// Channel   Direction  Handshake                    Payload
// cfg       in         cfg_we_i                     cfg_idx_i, cfg_data_i
// in        in         in_valid_i / in_ready_o      first_of_frame_i, ch0..ch2_in_i
// out       out        out_valid_o / out_ready_i    anchor_row/col_o, mean0..2_o
//
// A pixel that closes no window is paced by the single read port of the line
// store, which reads the stored rows of its column one at a time; a pixel that
// closes a window also waits for the column-sum memory reads and the
// bit-serial divider (16 restoring steps). One pixel is in work at a time;
// in_ready_o is high only while idle. The result register frees the core as
// soon as it is loaded, so a stalled output blocks only the next result. Reset
// clears control and position and restores the register defaults; the memories
// are not cleared.

module box_blur_window_mean_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bbm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bbm_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              first_of_frame_i,
  input  logic [bbm_pkg::PIX_W-1:0]         ch0_in_i,
  input  logic [bbm_pkg::PIX_W-1:0]         ch1_in_i,
  input  logic [bbm_pkg::PIX_W-1:0]         ch2_in_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [bbm_pkg::ROW_W-1:0]         anchor_row_o,
  output logic [bbm_pkg::COL_W-1:0]         anchor_col_o,
  output logic [bbm_pkg::PIX_W-1:0]         mean0_o,
  output logic [bbm_pkg::PIX_W-1:0]         mean1_o,
  output logic [bbm_pkg::PIX_W-1:0]         mean2_o
);

  bbm_pkg::cmd_t cmd;
  bbm_pkg::sts_t sts;

  bbm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bbm_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .first_of_frame_i (first_of_frame_i),
    .ch0_in_i         (ch0_in_i),
    .ch1_in_i         (ch1_in_i),
    .ch2_in_i         (ch2_in_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .anchor_row_o     (anchor_row_o),
    .anchor_col_o     (anchor_col_o),
    .mean0_o          (mean0_o),
    .mean1_o          (mean1_o),
    .mean2_o          (mean2_o)
  );

endmodule

[src/bbm_div.sv]
`include "assert_macros.svh"

module bbm_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [bbm_pkg::WSUM_W-1:0]         dividend_i,
  input  logic [bbm_pkg::AREA_W-1:0]         divisor_i,
  output logic                               busy_o,
  output logic [bbm_pkg::PIX_W-1:0]          quotient_o
);

  logic                          busy_q, busy_d;
  logic [bbm_pkg::DCNT_W-1:0]    cnt_q, cnt_d;
  logic [bbm_pkg::REM_W-1:0]     rem_q, rem_d;
  logic [bbm_pkg::WSUM_W-1:0]    quo_q, quo_d;
  logic [bbm_pkg::REM_W-1:0]     shifted;

  // One restoring step per cycle, quotient shifts in behind the dividend
  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    shifted = {rem_q[bbm_pkg::REM_W-2:0], quo_q[bbm_pkg::WSUM_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = bbm_pkg::DCNT_W'(bbm_pkg::WSUM_W);
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      if (shifted >= bbm_pkg::REM_W'(divisor_i)) begin
        rem_d = shifted - bbm_pkg::REM_W'(divisor_i);
        quo_d = {quo_q[bbm_pkg::WSUM_W-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[bbm_pkg::WSUM_W-2:0], 1'b0};
      end
      cnt_d  = cnt_q - 1'b1;
      busy_d = (cnt_q != bbm_pkg::DCNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q[bbm_pkg::PIX_W-1:0];

  `ASSERT_NEXT(a_div_start_busy, clk_i, rst_ni, start_i, busy_q, "divider did not start")
  `ASSERT_IMPL(a_div_cnt_live, clk_i, rst_ni, busy_q, cnt_q != '0, "divider count ran out while busy")
  `ASSERT_NEXT(a_div_last_step, clk_i, rst_ni, busy_q && cnt_q == bbm_pkg::DCNT_W'(1) && !start_i, !busy_q, "divider overran")

endmodule

[src/bbm_ctrl.sv]
`include "assert_macros.svh"

module bbm_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  bbm_pkg::sts_t         sts_i,
  output bbm_pkg::cmd_t         cmd_o
);

  bbm_pkg::ctrl_state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bbm_pkg::S_IDLE:  if (in_valid_i) state_d = bbm_pkg::S_COL;
      bbm_pkg::S_COL:   if (sts_i.col_done) state_d = bbm_pkg::S_WRITE;
      bbm_pkg::S_WRITE: state_d = sts_i.emit ? bbm_pkg::S_WIN : bbm_pkg::S_IDLE;
      bbm_pkg::S_WIN:   if (sts_i.win_done) state_d = bbm_pkg::S_DIV;
      bbm_pkg::S_DIV:   if (sts_i.div_done) state_d = bbm_pkg::S_OUT;
      bbm_pkg::S_OUT:   if (sts_i.out_free) state_d = bbm_pkg::S_IDLE;
      default:          state_d = bbm_pkg::S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o           = '0;
    in_ready_o      = 1'b0;
    unique case (state_q)
      bbm_pkg::S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.start = in_valid_i;
      end
      bbm_pkg::S_COL:   cmd_o.col_step = 1'b1;
      bbm_pkg::S_WRITE: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.advance = !sts_i.emit;
      end
      bbm_pkg::S_WIN: begin
        cmd_o.win_step  = 1'b1;
        cmd_o.div_start = sts_i.win_done;
      end
      bbm_pkg::S_DIV: ;
      bbm_pkg::S_OUT: begin
        cmd_o.load    = sts_i.out_free;
        cmd_o.advance = sts_i.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bbm_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `ASSERT_NEXT(a_accept_to_col, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == bbm_pkg::S_COL, "transfer did not start column pass")
  `ASSERT_NEXT(a_div_to_out, clk_i, rst_ni, state_q == bbm_pkg::S_DIV && sts_i.div_done, state_q == bbm_pkg::S_OUT, "divide done not followed by output")
  `ASSERT_NEXT(a_advance_idle, clk_i, rst_ni, cmd_o.advance, state_q == bbm_pkg::S_IDLE, "advance not followed by idle")

endmodule

[src/bbm_dp.sv]
`include "assert_macros.svh"

module bbm_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bbm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bbm_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                              first_of_frame_i,
  input  logic [bbm_pkg::PIX_W-1:0]         ch0_in_i,
  input  logic [bbm_pkg::PIX_W-1:0]         ch1_in_i,
  input  logic [bbm_pkg::PIX_W-1:0]         ch2_in_i,
  input  bbm_pkg::cmd_t                     cmd_i,
  output bbm_pkg::sts_t                     sts_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [bbm_pkg::ROW_W-1:0]         anchor_row_o,
  output logic [bbm_pkg::COL_W-1:0]         anchor_col_o,
  output logic [bbm_pkg::PIX_W-1:0]         mean0_o,
  output logic [bbm_pkg::PIX_W-1:0]         mean1_o,
  output logic [bbm_pkg::PIX_W-1:0]         mean2_o
);

  localparam int PXW = bbm_pkg::NCH * bbm_pkg::PIX_W;
  localparam int CSW = bbm_pkg::NCH * bbm_pkg::CSUM_W;

  // Configuration
  logic [bbm_pkg::CFG_W-1:0] cols_q, rows_q;
  logic [bbm_pkg::WIN_W-1:0] wr_q, wc_q;
  logic [bbm_pkg::CFG_W-1:0] cols_eff, rows_eff;
  logic [bbm_pkg::WIN_W-1:0] wr_eff, wc_eff;
  logic [bbm_pkg::AREA_W-1:0] area;

  // Position and item
  logic [bbm_pkg::ROW_W-1:0]  row_q;
  logic [bbm_pkg::COL_W-1:0]  col_q;
  logic [bbm_pkg::SLOT_W-1:0] slot_q;
  logic [PXW-1:0]             pix_q;

  // Sequencing
  logic [bbm_pkg::WIN_W-1:0]   k_q;
  logic [bbm_pkg::CFG_W-1:0]   j_q;
  logic                        rd_vld_q;
  logic [bbm_pkg::CSUM_W-1:0]  csum_q [bbm_pkg::NCH];
  logic [bbm_pkg::WSUM_W-1:0]  wsum_q [bbm_pkg::NCH];

  // Memories
  logic [PXW-1:0] ls_mem [0:bbm_pkg::STORE_ROWS*bbm_pkg::MAX_COLS-1];
  logic [CSW-1:0] cs_mem [0:bbm_pkg::MAX_COLS-1];
  logic [PXW-1:0] ls_rd_q;
  logic [CSW-1:0] cs_rd_q;
  logic [CSW-1:0] cs_wdata;

  // Derived
  logic                         col_issue, win_issue, emit;
  logic [bbm_pkg::WIN_W-1:0]    slot_sum;
  logic [bbm_pkg::SLOT_W-1:0]   slot_rd;
  logic [bbm_pkg::CFG_W-1:0]    col_nx, row_nx, c0, r0;
  logic [bbm_pkg::NCH-1:0]      div_busy;
  logic [bbm_pkg::PIX_W-1:0]    quo [bbm_pkg::NCH];

  // Output register
  logic                        out_valid_q;
  logic [bbm_pkg::ROW_W-1:0]   anchor_row_q;
  logic [bbm_pkg::COL_W-1:0]   anchor_col_q;
  logic [bbm_pkg::PIX_W-1:0]   mean_q [bbm_pkg::NCH];

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= bbm_pkg::CFG_W'(640);
      rows_q <= bbm_pkg::CFG_W'(480);
      wr_q   <= bbm_pkg::WIN_W'(3);
      wc_q   <= bbm_pkg::WIN_W'(3);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bbm_pkg::CFG_IMAGE_COLS: cols_q <= cfg_data_i;
        bbm_pkg::CFG_IMAGE_ROWS: rows_q <= cfg_data_i;
        bbm_pkg::CFG_WIN_ROWS:   wr_q   <= cfg_data_i[bbm_pkg::WIN_W-1:0];
        bbm_pkg::CFG_WIN_COLS:   wc_q   <= cfg_data_i[bbm_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp zero to one and large values to the maximum
  always_comb begin
    cols_eff = (cols_q == '0) ? bbm_pkg::CFG_W'(1) :
               (cols_q > bbm_pkg::CFG_W'(bbm_pkg::MAX_COLS)) ?
               bbm_pkg::CFG_W'(bbm_pkg::MAX_COLS) : cols_q;
    rows_eff = (rows_q == '0) ? bbm_pkg::CFG_W'(1) :
               (rows_q > bbm_pkg::CFG_W'(bbm_pkg::MAX_ROWS)) ?
               bbm_pkg::CFG_W'(bbm_pkg::MAX_ROWS) : rows_q;
    wr_eff   = (wr_q == '0) ? bbm_pkg::WIN_W'(1) :
               (wr_q > bbm_pkg::WIN_W'(bbm_pkg::MAX_WIN)) ?
               bbm_pkg::WIN_W'(bbm_pkg::MAX_WIN) : wr_q;
    wc_eff   = (wc_q == '0) ? bbm_pkg::WIN_W'(1) :
               (wc_q > bbm_pkg::WIN_W'(bbm_pkg::MAX_WIN)) ?
               bbm_pkg::WIN_W'(bbm_pkg::MAX_WIN) : wc_q;
    area     = bbm_pkg::AREA_W'(wr_eff) * bbm_pkg::AREA_W'(wc_eff);
  end

  // Addressing and status
  always_comb begin
    slot_sum  = bbm_pkg::WIN_W'(slot_q) + bbm_pkg::WIN_W'(bbm_pkg::STORE_ROWS) - k_q;
    slot_rd   = (slot_sum >= bbm_pkg::WIN_W'(bbm_pkg::STORE_ROWS)) ?
                bbm_pkg::SLOT_W'(slot_sum - bbm_pkg::WIN_W'(bbm_pkg::STORE_ROWS)) :
                bbm_pkg::SLOT_W'(slot_sum);
    col_issue = k_q < wr_eff;
    win_issue = j_q <= bbm_pkg::CFG_W'(col_q);
    r0        = bbm_pkg::CFG_W'(row_q) + 1'b1 - bbm_pkg::CFG_W'(wr_eff);
    c0        = bbm_pkg::CFG_W'(col_q) + 1'b1 - bbm_pkg::CFG_W'(wc_eff);
    emit      = (bbm_pkg::CFG_W'(row_q) + 1'b1 >= bbm_pkg::CFG_W'(wr_eff)) &&
                (bbm_pkg::CFG_W'(col_q) + 1'b1 >= bbm_pkg::CFG_W'(wc_eff));
    col_nx    = bbm_pkg::CFG_W'(col_q) + 1'b1;
    row_nx    = bbm_pkg::CFG_W'(row_q) + 1'b1;
    cs_wdata  = {csum_q[2], csum_q[1], csum_q[0]};
    sts_o.col_done = !col_issue && !rd_vld_q;
    sts_o.win_done = !win_issue && !rd_vld_q;
    sts_o.emit     = emit;
    sts_o.div_done = ~|div_busy;
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  // Line store: one read and one write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      ls_mem[{slot_q, col_q}] <= pix_q;
    end
    ls_rd_q <= ls_mem[{slot_rd, col_q}];
  end

  // Column sums
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      cs_mem[col_q] <= cs_wdata;
    end
    cs_rd_q <= cs_mem[j_q[bbm_pkg::COL_W-1:0]];
  end

  // Position: reset on frame mark, advance after each pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      slot_q <= '0;
    end else if (cmd_i.start && first_of_frame_i) begin
      row_q  <= '0;
      col_q  <= '0;
      slot_q <= '0;
    end else if (cmd_i.advance) begin
      if (col_nx >= cols_eff) begin
        col_q  <= '0;
        row_q  <= (row_nx >= rows_eff) ? '0 : row_nx[bbm_pkg::ROW_W-1:0];
        slot_q <= (slot_q == bbm_pkg::SLOT_W'(bbm_pkg::STORE_ROWS - 1)) ? '0 :
                  slot_q + 1'b1;
      end else begin
        col_q <= col_nx[bbm_pkg::COL_W-1:0];
      end
    end
  end

  // Read sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      k_q      <= '0;
      j_q      <= '0;
    end else if (cmd_i.start) begin
      rd_vld_q <= 1'b0;
      k_q      <= bbm_pkg::WIN_W'(1);
    end else if (cmd_i.col_step) begin
      rd_vld_q <= col_issue;
      if (col_issue) k_q <= k_q + 1'b1;
    end else if (cmd_i.wr_en) begin
      rd_vld_q <= 1'b0;
      j_q      <= c0;
    end else if (cmd_i.win_step) begin
      rd_vld_q <= win_issue;
      if (win_issue) j_q <= j_q + 1'b1;
    end
  end

  // Accumulate column and window sums
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      pix_q <= {ch2_in_i, ch1_in_i, ch0_in_i};
    end
    for (int ch = 0; ch < bbm_pkg::NCH; ch++) begin
      if (cmd_i.start) begin
        csum_q[ch] <= bbm_pkg::CSUM_W'(pix_q[0 +: 0+1] & 1'b0) |
                      (ch == 0 ? bbm_pkg::CSUM_W'(ch0_in_i) :
                       ch == 1 ? bbm_pkg::CSUM_W'(ch1_in_i) :
                                 bbm_pkg::CSUM_W'(ch2_in_i));
      end else if (cmd_i.col_step && rd_vld_q) begin
        csum_q[ch] <= csum_q[ch] +
                      bbm_pkg::CSUM_W'(ls_rd_q[bbm_pkg::PIX_W*ch +: bbm_pkg::PIX_W]);
      end
      if (cmd_i.wr_en) begin
        wsum_q[ch] <= '0;
      end else if (cmd_i.win_step && rd_vld_q) begin
        wsum_q[ch] <= wsum_q[ch] +
                      bbm_pkg::WSUM_W'(cs_rd_q[bbm_pkg::CSUM_W*ch +: bbm_pkg::CSUM_W]);
      end
    end
  end

  // Divide each channel sum by the window area
  for (genvar g = 0; g < bbm_pkg::NCH; g++) begin : g_div
    bbm_div u_div (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (cmd_i.div_start),
      .dividend_i (wsum_q[g]),
      .divisor_i  (area),
      .busy_o     (div_busy[g]),
      .quotient_o (quo[g])
    );
  end

  // Output register: hold until transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      anchor_row_q <= r0[bbm_pkg::ROW_W-1:0];
      anchor_col_q <= c0[bbm_pkg::COL_W-1:0];
      for (int ch = 0; ch < bbm_pkg::NCH; ch++) begin
        mean_q[ch] <= quo[ch];
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign anchor_row_o = anchor_row_q;
  assign anchor_col_o = anchor_col_q;
  assign mean0_o      = mean_q[0];
  assign mean1_o      = mean_q[1];
  assign mean2_o      = mean_q[2];

  `ASSERT_IMPL(a_no_overwrite, clk_i, rst_ni, out_valid_q && !out_ready_i, !cmd_i.load, "result overwritten before transfer")
  `ASSERT_IMPL(a_div_idle_load, clk_i, rst_ni, cmd_i.load, ~|div_busy, "result loaded while divider busy")
  `ASSERT_IMPL(a_col_in_range, clk_i, rst_ni, cmd_i.wr_en, slot_q < bbm_pkg::SLOT_W'(bbm_pkg::STORE_ROWS), "store slot out of range")

endmodule
